// File: rtl/core/swed_pkg.sv
// ----------------------------------------------------------------------------
// swed_pkg
// Shared types and constants of the sparse weighted euclidean distance block:
// beat payloads, op codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package swed_pkg;

  localparam int VocabSizeDef    = 4096;
  localparam int MaxDocumentsDef = 65536;

  localparam int OpW      = 3;
  localparam int DocW     = 16;
  localparam int TermW    = 12;
  localparam int ValW     = 16;
  localparam int DistW    = 32;
  localparam int SumW     = 64;
  localparam int SqW      = 2 * ValW;
  localparam int ProdW    = SqW + ValW;
  localparam int TermSpan = 1 << TermW;
  localparam int RootCntW = $clog2(DistW);

  typedef enum logic [OpW-1:0] {
    OP_WEIGHT    = 3'd0,
    OP_REFERENCE = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_TARGET    = 3'd3,
    OP_FINISH    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SQUARE,
    ST_SCALE,
    ST_ACC,
    ST_ROOT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [DocW-1:0] doc;
    logic [TermW-1:0] term;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DocW-1:0]  doc_out;
    logic [DistW-1:0] distance;
  } out_item_t;

  typedef struct packed {
    logic item_load;
    logic wr_weight;
    logic wr_ref;
    logic clr_wr;
    logic run_set;
    logic run_close;
    logic sqrt_start;
    logic out_load;
    logic sum_clear;
    logic sq_en;
    logic prod_en;
    logic acc_en;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic term_ok;
    logic doc_ok;
    logic doc_change;
    logic run_open;
    logic clr_last;
    logic root_done;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/sparse_weighted_euclidean_distance.sv
// ----------------------------------------------------------------------------
// sparse_weighted_euclidean_distance
// Streams sparse target documents against one loaded reference distribution
// and returns, per document, floor(sqrt(sum of weight*(value-ref)^2)) in
// Q20.12 from a saturating 64-bit Q40.24 sum. After reset the reference valid
// marks are swept clear, one term per cycle, over the first min(VOCAB_SIZE,
// 4096) terms before in_ready_o rises; a clear op repeats that sweep. A
// target entry passes through the registered table read, the square multiply
// and the weight multiply ahead of the accumulator, unless its term lies
// beyond the vocabulary, when it skips them. A beat that closes a document
// first runs the bit-serial square root and waits for the output register
// to drain.
// ----------------------------------------------------------------------------
module sparse_weighted_euclidean_distance #(
  parameter int VOCAB_SIZE    = swed_pkg::VocabSizeDef,
  parameter int MAX_DOCUMENTS = swed_pkg::MaxDocumentsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swed_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swed_pkg::out_item_t  out_item_o
);

  swed_pkg::ctrl_cmd_t  cmd;
  swed_pkg::dp_status_t status;

  swed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swed_dp #(
    .VOCAB_SIZE    (VOCAB_SIZE),
    .MAX_DOCUMENTS (MAX_DOCUMENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/core/swed_sqrt.sv
// ----------------------------------------------------------------------------
// swed_sqrt
// Iterative integer square root of the 64-bit sum, one root bit per cycle,
// truncated toward zero.
// ----------------------------------------------------------------------------
module swed_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [swed_pkg::SumW-1:0]     radicand_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [swed_pkg::DistW-1:0]    root_o
);

  localparam int RemW = swed_pkg::DistW + 2;
  localparam int ShW  = RemW + 2;

  logic                            busy_q, done_q;
  logic [swed_pkg::RootCntW-1:0]   cnt_q;
  logic [swed_pkg::SumW-1:0]       x_q;
  logic [RemW-1:0]                 rem_q;
  logic [swed_pkg::DistW-1:0]      res_q;
  logic [ShW-1:0]                  rem_sh, trial, rem_sub;
  logic                            fits;

  assign rem_sh  = {rem_q, x_q[swed_pkg::SumW-1 -: 2]};
  assign trial   = {2'b00, res_q, 2'b01};
  assign fits    = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == swed_pkg::RootCntW'(swed_pkg::DistW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      rem_q <= '0;
      res_q <= '0;
    end else if (busy_q) begin
      x_q   <= {x_q[swed_pkg::SumW-3:0], 2'b00};
      rem_q <= fits ? rem_sub[RemW-1:0] : rem_sh[RemW-1:0];
      res_q <= {res_q[swed_pkg::DistW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = res_q;

endmodule

// File: rtl/core/swed_dp.sv
// ----------------------------------------------------------------------------
// swed_dp
// Datapath: item register, weight and reference memories with clear sweep,
// square and weight multipliers, saturating accumulator, root unit and the
// output register.
// ----------------------------------------------------------------------------
module swed_dp #(
  parameter int VOCAB_SIZE    = swed_pkg::VocabSizeDef,
  parameter int MAX_DOCUMENTS = swed_pkg::MaxDocumentsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swed_pkg::in_item_t    in_item_i,
  input  swed_pkg::ctrl_cmd_t   cmd_i,
  output swed_pkg::dp_status_t  status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output swed_pkg::out_item_t   out_item_o
);

  localparam int Depth = (VOCAB_SIZE < swed_pkg::TermSpan) ? VOCAB_SIZE : swed_pkg::TermSpan;
  localparam int AddrW = $clog2(Depth);
  localparam int RefW  = swed_pkg::ValW + 1;

  swed_pkg::in_item_t                item_q;
  logic                              run_open_q;
  logic [swed_pkg::DocW-1:0]         cur_doc_q;
  logic [swed_pkg::SumW-1:0]         sum_q;
  logic [AddrW-1:0]                  clr_cnt_q;
  logic [swed_pkg::ValW-1:0]         weight_mem [Depth];
  logic [RefW-1:0]                   ref_mem [Depth];
  logic [swed_pkg::ValW-1:0]         weight_rd_q;
  logic [RefW-1:0]                   ref_rd_q;
  logic [swed_pkg::SqW-1:0]          sq_q;
  logic [swed_pkg::ValW-1:0]         wgt_q;
  logic [swed_pkg::ProdW-1:0]        prod_q;
  logic                              out_valid_q;
  swed_pkg::out_item_t               out_item_q;

  logic [AddrW-1:0]                  term_addr, ref_wr_addr;
  logic                              ref_wr_en;
  logic [RefW-1:0]                   ref_wr_data;
  logic [swed_pkg::ValW-1:0]         ref_val, diff;
  logic [swed_pkg::SumW:0]           sum_add;
  logic                              term_ok, doc_ok, clr_last, out_free;
  logic                              root_busy, root_done;
  logic [swed_pkg::DistW-1:0]        root;

  assign term_addr   = item_q.term[AddrW-1:0];
  assign term_ok     = 32'(item_q.term) < 32'(VOCAB_SIZE);
  assign doc_ok      = 32'(item_q.doc) < 32'(MAX_DOCUMENTS);
  assign clr_last    = clr_cnt_q == AddrW'(Depth - 1);
  assign out_free    = !out_valid_q || out_ready_i;
  assign ref_wr_en   = cmd_i.wr_ref || cmd_i.clr_wr;
  assign ref_wr_addr = cmd_i.clr_wr ? clr_cnt_q : term_addr;
  assign ref_wr_data = cmd_i.clr_wr ? '0 : {1'b1, item_q.value};

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_weight) begin
      weight_mem[term_addr] <= item_q.value;
    end
    weight_rd_q <= weight_mem[term_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ref_wr_en) begin
      ref_mem[ref_wr_addr] <= ref_wr_data;
    end
    ref_rd_q <= ref_mem[term_addr];
  end

  // clear sweep counter rests at zero between sweeps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
    end
  end

  assign ref_val = ref_rd_q[swed_pkg::ValW-1:0];

  always_comb begin
    if (!ref_rd_q[RefW-1]) begin
      diff = item_q.value;
    end else if (item_q.value >= ref_val) begin
      diff = item_q.value - ref_val;
    end else begin
      diff = ref_val - item_q.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sq_q  <= swed_pkg::SqW'(diff) * swed_pkg::SqW'(diff);
      wgt_q <= weight_rd_q;
    end
    if (cmd_i.prod_en) begin
      prod_q <= swed_pkg::ProdW'(sq_q) * swed_pkg::ProdW'(wgt_q);
    end
  end

  assign sum_add = {1'b0, sum_q} + {(swed_pkg::SumW + 1 - swed_pkg::ProdW)'(0), prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      run_open_q <= 1'b0;
      cur_doc_q  <= '0;
    end else begin
      if (cmd_i.sum_clear) begin
        sum_q <= '0;
      end else if (cmd_i.acc_en) begin
        sum_q <= sum_add[swed_pkg::SumW] ? '1 : sum_add[swed_pkg::SumW-1:0];
      end
      if (cmd_i.run_set) begin
        run_open_q <= 1'b1;
        cur_doc_q  <= item_q.doc;
      end else if (cmd_i.run_close) begin
        run_open_q <= 1'b0;
      end
    end
  end

  swed_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (sum_q),
    .busy_o     (root_busy),
    .done_o     (root_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.doc_out  <= cur_doc_q;
      out_item_q.distance <= root;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.op         = swed_pkg::op_e'(item_q.op);
  assign status_o.term_ok    = term_ok;
  assign status_o.doc_ok     = doc_ok;
  assign status_o.doc_change = run_open_q && (item_q.doc != cur_doc_q);
  assign status_o.run_open   = run_open_q;
  assign status_o.clr_last   = clr_last;
  assign status_o.root_done  = root_done;
  assign status_o.out_free   = out_free;

  a_root_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sqrt_start |-> !root_busy)
    else $error("root unit restarted while busy");

  a_out_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output register overwritten before its beat was taken");

  a_acc_after_prod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_en |-> $past(cmd_i.prod_en))
    else $error("accumulate without a fresh product");

  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_weight || cmd_i.wr_ref) |-> term_ok)
    else $error("table write beyond vocabulary");

  a_sweep_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_wr |-> !cmd_i.wr_ref && !cmd_i.item_load)
    else $error("clear sweep overlaps another access");

endmodule

// File: rtl/core/swed_ctrl.sv
// ----------------------------------------------------------------------------
// swed_ctrl
// Controller: sequences table writes, clear sweeps, the per-entry multiply and
// accumulate, the root of a finished document and its output beat.
// ----------------------------------------------------------------------------
module swed_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  swed_pkg::dp_status_t  status_i,
  output swed_pkg::ctrl_cmd_t   cmd_o
);

  swed_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swed_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      swed_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = swed_pkg::ST_IDLE;
        end
      end
      swed_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = swed_pkg::ST_DISPATCH;
        end
      end
      swed_pkg::ST_DISPATCH: begin
        state_d = swed_pkg::ST_IDLE;
        case (status_i.op)
          swed_pkg::OP_WEIGHT: begin
            cmd_o.wr_weight = status_i.term_ok;
          end
          swed_pkg::OP_REFERENCE: begin
            cmd_o.wr_ref = status_i.term_ok;
          end
          swed_pkg::OP_CLEAR: begin
            state_d = swed_pkg::ST_CLEAR;
          end
          swed_pkg::OP_TARGET: begin
            if (status_i.doc_ok) begin
              if (status_i.doc_change) begin
                cmd_o.sqrt_start = 1'b1;
                state_d          = swed_pkg::ST_ROOT;
              end else begin
                cmd_o.run_set = 1'b1;
                if (status_i.term_ok) begin
                  state_d = swed_pkg::ST_SQUARE;
                end
              end
            end
          end
          swed_pkg::OP_FINISH: begin
            if (status_i.run_open) begin
              cmd_o.sqrt_start = 1'b1;
              state_d          = swed_pkg::ST_ROOT;
            end
          end
          default: begin
            state_d = swed_pkg::ST_IDLE;
          end
        endcase
      end
      swed_pkg::ST_ROOT: begin
        if (status_i.root_done) begin
          state_d = swed_pkg::ST_EMIT;
        end
      end
      swed_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.sum_clear = 1'b1;
          if (status_i.op == swed_pkg::OP_TARGET) begin
            cmd_o.run_set = 1'b1;
            state_d = status_i.term_ok ? swed_pkg::ST_SQUARE : swed_pkg::ST_IDLE;
          end else begin
            cmd_o.run_close = 1'b1;
            state_d         = swed_pkg::ST_IDLE;
          end
        end
      end
      swed_pkg::ST_SQUARE: begin
        cmd_o.sq_en = 1'b1;
        state_d     = swed_pkg::ST_SCALE;
      end
      swed_pkg::ST_SCALE: begin
        cmd_o.prod_en = 1'b1;
        state_d       = swed_pkg::ST_ACC;
      end
      swed_pkg::ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = swed_pkg::ST_IDLE;
      end
      default: begin
        state_d = swed_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = state_q == swed_pkg::ST_IDLE;

endmodule

// File: test/swed_distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swed_distance_checker
// Watches both channels of the sparse weighted euclidean distance block. It
// keeps its own weight table, reference table, valid marks and open document
// sum, predicts the distance beat that each accepted input beat causes, and
// compares every accepted output beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module swed_distance_checker
  import swed_pkg::*;
#(
  parameter int VOCAB_SIZE    = VocabSizeDef,
  parameter int MAX_DOCUMENTS = MaxDocumentsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        beat_count_o,
  output int        dist_count_o
);

  logic [ValW-1:0] weight_q  [VOCAB_SIZE];
  logic [ValW-1:0] ref_val_q [VOCAB_SIZE];
  logic            ref_mark_q[VOCAB_SIZE];
  logic [SumW-1:0] dist_sum;
  logic [DocW-1:0] open_doc;
  logic            doc_open;
  out_item_t       dist_expect_q[$];

  function automatic logic [DistW-1:0] floor_root(input logic [SumW-1:0] x);
    logic [DistW-1:0] root;
    logic [DistW-1:0] trial;
    root = '0;
    for (int b = DistW - 1; b >= 0; b--) begin
      trial = root | (DistW'(1) << b);
      if (SumW'(trial) * SumW'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  task automatic close_doc();
    out_item_t res;
    res.doc_out  = open_doc;
    res.distance = floor_root(dist_sum);
    dist_expect_q.push_back(res);
    dist_sum = '0;
  endtask

  task automatic predict_beat(input in_item_t beat);
    logic            term_ok;
    logic [ValW-1:0] diff;
    logic [ValW-1:0] ref_val;
    logic [SqW-1:0]  sq;
    logic [SumW-1:0] inc;
    term_ok = int'(beat.term) < VOCAB_SIZE;
    case (beat.op)
      OP_WEIGHT: begin
        if (term_ok) weight_q[beat.term] = beat.value;
      end
      OP_REFERENCE: begin
        if (term_ok) begin
          ref_val_q[beat.term]  = beat.value;
          ref_mark_q[beat.term] = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int t = 0; t < VOCAB_SIZE; t++) ref_mark_q[t] = 1'b0;
      end
      OP_TARGET: begin
        if (int'(beat.doc) < MAX_DOCUMENTS) begin
          if (doc_open && beat.doc != open_doc) close_doc();
          open_doc = beat.doc;
          doc_open = 1'b1;
          if (term_ok) begin
            diff = beat.value;
            if (ref_mark_q[beat.term]) begin
              ref_val = ref_val_q[beat.term];
              diff = (beat.value >= ref_val) ? beat.value - ref_val : ref_val - beat.value;
            end
            sq  = SqW'(diff) * SqW'(diff);
            inc = SumW'(sq) * SumW'(weight_q[beat.term]);
            // saturate instead of wrapping
            if (dist_sum > ~inc) dist_sum = '1;
            else dist_sum = dist_sum + inc;
          end
        end
      end
      OP_FINISH: begin
        if (doc_open) begin
          close_doc();
          doc_open = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int t = 0; t < VOCAB_SIZE; t++) begin
        weight_q[t]   = '0;
        ref_val_q[t]  = '0;
        ref_mark_q[t] = 1'b0;
      end
      dist_sum = '0;
      open_doc = '0;
      doc_open = 1'b0;
      dist_expect_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.op <= OP_FINISH) beat_count_o++;
        predict_beat(in_item_i);
      end
      if (out_valid_i && out_ready_i) begin
        dist_count_o++;
        if (dist_expect_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: unexpected distance beat doc %h distance %h", $time,
                     out_item_i.doc_out, out_item_i.distance);
          end
          fail_count_o++;
        end else begin
          want = dist_expect_q.pop_front();
          if (out_item_i.doc_out !== want.doc_out || out_item_i.distance !== want.distance) begin
            if (fail_count_o < 10) begin
              $display("%0t: distance mismatch expected doc %h distance %h, got doc %h distance %h",
                       $time, want.doc_out, want.distance, out_item_i.doc_out,
                       out_item_i.distance);
            end
            fail_count_o++;
          end
        end
      end
    end
    pending_o = dist_expect_q.size();
  end

endmodule

// File: test/tb_sparse_weighted_euclidean_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_weighted_euclidean_distance
// Drives weight, reference, clear, target and finish beats into the block:
// a directed opening over the field extremes and every op, random document
// runs with random gaps on both channels, a gap-free stretch, and one
// document of full-scale entries with the largest weight. A checker beside
// the block predicts and compares every distance beat.
// ----------------------------------------------------------------------------
module tb_sparse_weighted_euclidean_distance;
  import swed_pkg::*;

  localparam int               StallLimit  = 20000;
  localparam int               FullEntries = 48;
  localparam logic [OpW-1:0]   OpUnusedLo  = 3'd5;
  localparam logic [OpW-1:0]   OpUnusedHi  = 3'd7;
  localparam logic [TermW-1:0] FullTerm    = 12'h0a5;
  localparam logic [DocW-1:0]  FullDoc     = 16'h5a5a;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  int fail_count;
  int pending;
  int beat_count;
  int dist_count;
  int quiet_cycles = 0;
  int useful_beats = 0;
  int target_count = 0;
  int clear_count  = 0;
  bit src_idle_en  = 1'b0;
  bit snk_stall_en = 1'b0;

  bit              weight_set[TermSpan];
  logic [TermW-1:0] weighted_terms[$];
  logic [DocW-1:0]  last_doc = '0;

  sparse_weighted_euclidean_distance u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

  swed_distance_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .in_item_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beat_count_o (beat_count),
    .dist_count_o (dist_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (snk_stall_en && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("tb_sparse_weighted_euclidean_distance: FAIL");
    $finish;
  end

  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ValW'($urandom);
    endcase
  endfunction

  function automatic logic [DocW-1:0] rand_doc();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return DocW'($urandom);
    endcase
  endfunction

  function automatic logic [TermW-1:0] pool_term();
    return weighted_terms[$urandom_range(0, weighted_terms.size() - 1)];
  endfunction

  task automatic drive(input logic [OpW-1:0] op, input logic [DocW-1:0] doc,
                       input logic [TermW-1:0] term, input logic [ValW-1:0] value);
    in_item_t beat;
    beat.op    = op;
    beat.doc   = doc;
    beat.term  = term;
    beat.value = value;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (op == OP_WEIGHT && !weight_set[term]) begin
      weight_set[term] = 1'b1;
      weighted_terms.push_back(term);
    end
    if (op == OP_TARGET) target_count++;
    if (op == OP_CLEAR) clear_count++;
    if (op <= OP_FINISH) useful_beats++;
  endtask

  task automatic directed_beats();
    // finish with no open document, then the unused codes
    drive(OP_FINISH, '1, '1, '1);
    for (int code = OpUnusedLo; code <= OpUnusedHi; code++) drive(OpW'(code), '1, '1, '1);
    drive(OP_WEIGHT, '0, 12'd0, 16'hffff);
    drive(OP_WEIGHT, '1, 12'd4095, 16'h0001);
    drive(OP_WEIGHT, '0, 12'd5, 16'h0100);
    drive(OP_WEIGHT, '0, 12'd6, 16'h0000);
    drive(OP_REFERENCE, '0, 12'd4095, 16'hffff);
    drive(OP_REFERENCE, '0, 12'd5, 16'h0200);
    drive(OP_TARGET, 16'h0000, 12'd0, 16'hffff);
    drive(OP_TARGET, 16'h0000, 12'd4095, 16'h0000);
    drive(OP_TARGET, 16'h0000, 12'd5, 16'h0100);
    drive(OP_TARGET, 16'h0000, 12'd5, 16'h0300);
    drive(OP_TARGET, 16'hffff, 12'd6, 16'h1234);
    // clear keeps the open document
    drive(OP_CLEAR, '1, '1, '0);
    drive(OP_TARGET, 16'hffff, 12'd5, 16'h0300);
    drive(OP_TARGET, 16'hffff, 12'd0, 16'h0000);
    drive(OP_FINISH, '0, '0, '0);
    drive(OP_FINISH, '0, '0, '0);
    drive(OP_TARGET, 16'h0001, 12'd4095, 16'h0000);
    drive(OP_FINISH, '0, '0, '0);
  endtask

  task automatic random_traffic(input int budget);
    int              stop_at;
    int              run_len;
    logic [DocW-1:0] doc;
    stop_at = useful_beats + budget;
    while (weighted_terms.size() < 16) begin
      drive(OP_WEIGHT, rand_doc(), TermW'($urandom), rand_value());
    end
    for (int k = 0; k < 8; k++) drive(OP_REFERENCE, rand_doc(), pool_term(), rand_value());
    while (useful_beats < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          drive(OP_WEIGHT, rand_doc(),
                $urandom_range(0, 1) ? pool_term() : TermW'($urandom), rand_value());
        end
        2, 3: begin
          drive(OP_REFERENCE, rand_doc(),
                $urandom_range(0, 3) ? pool_term() : TermW'($urandom), rand_value());
        end
        4: begin
          if ($urandom_range(0, 1)) begin
            drive(OP_CLEAR, rand_doc(), TermW'($urandom), rand_value());
          end else begin
            drive(OpW'($urandom_range(OpUnusedLo, OpUnusedHi)), rand_doc(),
                  TermW'($urandom), rand_value());
          end
        end
        5: begin
          drive(OP_FINISH, rand_doc(), TermW'($urandom), rand_value());
        end
        default: begin
          doc = ($urandom_range(0, 3) == 0) ? last_doc : rand_doc();
          run_len = $urandom_range(1, 8);
          for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
              drive(OP_REFERENCE, rand_doc(), pool_term(), rand_value());
            end
            drive(OP_TARGET, doc, pool_term(), rand_value());
          end
          last_doc = doc;
        end
      endcase
    end
  endtask

  task automatic full_scale_doc();
    drive(OP_CLEAR, '0, '0, '0);
    drive(OP_WEIGHT, '0, FullTerm, '1);
    for (int k = 0; k < FullEntries; k++) drive(OP_TARGET, FullDoc, FullTerm, '1);
    drive(OP_FINISH, '0, '0, '0);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_beats();
    src_idle_en  = 1'b1;
    snk_stall_en = 1'b1;
    random_traffic(680);
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    random_traffic(120);
    full_scale_doc();
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("run covered %0d beats: %0d target entries, %0d reference clears, %0d distances",
             beat_count, target_count, clear_count, dist_count);
    $display("including one document of %0d full-scale entries at the largest weight",
             FullEntries);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_sparse_weighted_euclidean_distance: PASS");
    end else begin
      $display("tb_sparse_weighted_euclidean_distance: FAIL");
    end
    $finish;
  end

endmodule
